// ----- rtl/ffpa_pkg.sv -----
// Shared types and constants for the first-fit partition allocator.
`default_nettype none
package ffpa_pkg;
  localparam int unsigned RegBits = 24;

  localparam logic [2:0] ST_ALLOCATED    = 3'd0;
  localparam logic [2:0] ST_NO_FIT       = 3'd1;
  localparam logic [2:0] ST_NO_USED_SLOT = 3'd2;
  localparam logic [2:0] ST_RECLAIMED    = 3'd3;
  localparam logic [2:0] ST_JOB_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_NO_FREE_SLOT = 3'd5;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RECLAIM = 1'b1;

  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_POOL_LENGTH = 2'd1;
  localparam logic [1:0] REG_MIN_SPLIT   = 2'd2;

  localparam logic [23:0] POOL_BASE_RST   = 24'd10240;
  localparam logic [23:0] POOL_LENGTH_RST = 24'd102400;
  localparam logic [23:0] MIN_SPLIT_RST   = 24'd100;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  job_id;
    logic [23:0] request_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] block_address;
    logic [23:0] block_length;
  } out_word_t;
endpackage
`default_nettype wire

// ----- rtl/ffpa_free_cell.sv -----
// One free-table entry; rotates its contents to its neighbor while the ring shifts.
`default_nettype none
module ffpa_free_cell #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  wire                  clk,
  input  wire                  load,
  input  wire                  shift,
  input  wire                  wr,
  input  wire                  ld_valid,
  input  wire  [ADDR_BITS-1:0] ld_start,
  input  wire  [ADDR_BITS-1:0] ld_size,
  input  wire                  sh_valid,
  input  wire  [ADDR_BITS-1:0] sh_start,
  input  wire  [ADDR_BITS-1:0] sh_size,
  input  wire                  wr_valid,
  input  wire  [ADDR_BITS-1:0] wr_start,
  input  wire  [ADDR_BITS-1:0] wr_size,
  output logic                 valid_r,
  output logic [ADDR_BITS-1:0] start_r,
  output logic [ADDR_BITS-1:0] size_r
);
  always_ff @(posedge clk) begin
    if (load) begin
      valid_r <= ld_valid;
      start_r <= ld_start;
      size_r  <= ld_size;
    end else if (wr) begin
      valid_r <= wr_valid;
      start_r <= wr_start;
      size_r  <= wr_size;
    end else if (shift) begin
      valid_r <= sh_valid;
      start_r <= sh_start;
      size_r  <= sh_size;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/ffpa_used_cell.sv -----
// One allocated-table entry; rotates its contents to its neighbor while the ring shifts.
`default_nettype none
module ffpa_used_cell #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  wire                  clk,
  input  wire                  load,
  input  wire                  shift,
  input  wire                  wr,
  input  wire  [7:0]           sh_owner,
  input  wire  [ADDR_BITS-1:0] sh_start,
  input  wire  [ADDR_BITS-1:0] sh_size,
  input  wire  [7:0]           wr_owner,
  input  wire  [ADDR_BITS-1:0] wr_start,
  input  wire  [ADDR_BITS-1:0] wr_size,
  output logic [7:0]           owner_r,
  output logic [ADDR_BITS-1:0] start_r,
  output logic [ADDR_BITS-1:0] size_r
);
  always_ff @(posedge clk) begin
    if (load) begin
      owner_r <= '0;
      start_r <= '0;
      size_r  <= '0;
    end else if (wr) begin
      owner_r <= wr_owner;
      start_r <= wr_start;
      size_r  <= wr_size;
    end else if (shift) begin
      owner_r <= sh_owner;
      start_r <= sh_start;
      size_r  <= sh_size;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/first_fit_partition_allocator.sv -----
// Top level: first-fit partition allocator built from two rotating rings of cells.
// One request at a time: the next word is taken the cycle after the result leaves.
// Each table is a ring rotated one place a cycle while it is scanned; only the head
// cell (index 0) is examined.
// Synchronous reset reloads both tables; a write to pool_base or pool_length does too.
`default_nettype none
module first_fit_partition_allocator #(
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned USED_ENTRIES = 16,
  parameter int unsigned ADDR_BITS    = 24
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ffpa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ffpa_pkg::out_word_t out_data,
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire  [3:0]          cfg_paddr,
  input  wire  [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned UCW = $clog2(USED_ENTRIES + 1);
  localparam logic [FCW-1:0] FREE_N = FCW'(FREE_ENTRIES);
  localparam logic [UCW-1:0] USED_N = UCW'(USED_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_U_FIND, S_U_BACK, S_F_FIND, S_F_BACK, S_U_WRITE,
    S_MERGE, S_SLOT, S_F_BACK2, S_U_CLEAR, S_DONE
  } state_t;

  state_t state_r;
  ffpa_pkg::in_word_t req_r;
  logic [23:0] pool_base_r, pool_length_r, min_split_r;
  logic [FCW-1:0] fcnt_r;
  logic [UCW-1:0] ucnt_r;
  logic found_r;
  logic slot_ok_r;
  logic [ADDR_BITS-1:0] a_r, l_r;
  logic [2:0] st_r;

  // cell rows
  logic f_valid [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] f_start [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] f_size  [FREE_ENTRIES];
  logic [7:0] u_owner [USED_ENTRIES];
  logic [ADDR_BITS-1:0] u_start [USED_ENTRIES];
  logic [ADDR_BITS-1:0] u_size  [USED_ENTRIES];

  logic cfg_wr, reload, f_shift, u_shift, f_wr, u_wr;
  logic fw_valid;
  logic [ADDR_BITS-1:0] fw_start, fw_size, uw_start, uw_size;
  logic [7:0] uw_owner;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign reload = !rst_n || (cfg_wr && (cfg_paddr[3:2] == ffpa_pkg::REG_POOL_BASE ||
                  cfg_paddr[3:2] == ffpa_pkg::REG_POOL_LENGTH));

  always_comb begin
    unique case (cfg_paddr[3:2])
      ffpa_pkg::REG_POOL_BASE:   cfg_prdata = {8'd0, pool_base_r};
      ffpa_pkg::REG_POOL_LENGTH: cfg_prdata = {8'd0, pool_length_r};
      ffpa_pkg::REG_MIN_SPLIT:   cfg_prdata = {8'd0, min_split_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // head-cell views
  logic [ADDR_BITS-1:0] req_len, f_end, u_end, rest, sum;
  assign req_len = req_r.request_length[ADDR_BITS-1:0];
  assign f_end   = f_start[0] + f_size[0];
  assign u_end   = a_r + l_r;
  assign rest    = f_size[0] - req_len;
  assign sum     = f_size[0] + l_r;

  logic [ADDR_BITS-1:0] min_split_a;
  logic min_hi;
  generate
    if (ADDR_BITS >= 24) begin : g_ms_wide
      assign min_split_a = ADDR_BITS'(min_split_r);
      assign min_hi = 1'b0;
    end else begin : g_ms_narrow
      assign min_split_a = min_split_r[ADDR_BITS-1:0];
      assign min_hi = |min_split_r[23:ADDR_BITS];
    end
  endgenerate
  logic small_rest;
  assign small_rest = min_hi || (rest < min_split_a);

  // head matches: fitting free area, adjoining free area, used slot wanted
  logic f_fit, f_adj, u_hit;
  logic [ADDR_BITS-1:0] carve_a, carve_l;
  assign f_fit = f_valid[0] && f_size[0] >= req_len;
  assign f_adj = f_valid[0] && (f_end == a_r || f_start[0] == u_end);
  assign u_hit = (req_r.req_type == ffpa_pkg::REQ_ALLOC) ? (u_owner[0] == 8'd0) :
                 (u_owner[0] == req_r.job_id);
  assign carve_a = small_rest ? f_start[0] : f_start[0] + rest;
  assign carve_l = small_rest ? f_size[0] : req_len;

  // control: head write vs. rotation
  always_comb begin
    f_shift = 1'b0; u_shift = 1'b0; f_wr = 1'b0; u_wr = 1'b0;
    fw_valid = f_valid[0]; fw_start = f_start[0]; fw_size = f_size[0];
    uw_owner = req_r.job_id; uw_start = a_r; uw_size = l_r;
    unique case (state_r)
      S_U_FIND, S_U_BACK, S_F_BACK, S_F_BACK2: begin
        u_shift = (state_r == S_U_FIND || state_r == S_U_BACK);
        f_shift = (state_r == S_F_BACK || state_r == S_F_BACK2);
      end
      S_F_FIND: begin
        f_shift = 1'b1;
        // carve only when a used slot is known to be free
        if (slot_ok_r && !found_r && f_fit) begin
          f_wr = 1'b1;
          if (small_rest) begin
            fw_valid = 1'b0; fw_size = '0;
          end else begin
            fw_size = rest;
          end
        end
      end
      S_MERGE: begin
        f_shift = 1'b1;
        if (!found_r && f_valid[0]) begin
          if (f_end == a_r) begin
            f_wr = 1'b1; fw_size = sum;
          end else if (f_start[0] == u_end) begin
            f_wr = 1'b1; fw_start = a_r; fw_size = sum;
          end
        end
      end
      S_SLOT: begin
        f_shift = 1'b1;
        if (!found_r && !f_valid[0]) begin
          f_wr = 1'b1; fw_valid = 1'b1; fw_start = a_r; fw_size = l_r;
        end
      end
      S_U_WRITE: begin
        u_shift = 1'b1;
        if (!found_r && u_owner[0] == 8'd0) begin
          u_wr = 1'b1;
        end
      end
      S_U_CLEAR: begin
        u_shift = 1'b1;
        if (!found_r && u_owner[0] == req_r.job_id) begin
          u_wr = 1'b1; uw_owner = '0; uw_start = '0; uw_size = '0;
        end
      end
      default: ;
    endcase
  end

  // A write at the head lands in the tail cell so rotation keeps going.
  genvar gi;
  generate
    for (gi = 0; gi < FREE_ENTRIES; gi++) begin : g_free
      localparam int unsigned NX = (gi + 1) % FREE_ENTRIES;
      logic wr_here;
      assign wr_here = f_wr && (gi == FREE_ENTRIES - 1);
      ffpa_free_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk(clk), .load(reload), .shift(f_shift), .wr(wr_here),
        .ld_valid(gi == 0),
        .ld_start(gi == 0 ? (ADDR_BITS)'(ffpa_pkg::RegBits'(
                    rst_n ? (cfg_wr && cfg_paddr[3:2] == ffpa_pkg::REG_POOL_BASE ?
                    cfg_pwdata[23:0] : pool_base_r) : ffpa_pkg::POOL_BASE_RST)) : '0),
        .ld_size(gi == 0 ? (ADDR_BITS)'(ffpa_pkg::RegBits'(
                    rst_n ? (cfg_wr && cfg_paddr[3:2] == ffpa_pkg::REG_POOL_LENGTH ?
                    cfg_pwdata[23:0] : pool_length_r) : ffpa_pkg::POOL_LENGTH_RST)) : '0),
        .sh_valid(f_valid[NX]), .sh_start(f_start[NX]), .sh_size(f_size[NX]),
        .wr_valid(fw_valid), .wr_start(fw_start), .wr_size(fw_size),
        .valid_r(f_valid[gi]), .start_r(f_start[gi]), .size_r(f_size[gi])
      );
    end
    for (gi = 0; gi < USED_ENTRIES; gi++) begin : g_used
      localparam int unsigned NX = (gi + 1) % USED_ENTRIES;
      logic wr_here;
      assign wr_here = u_wr && (gi == USED_ENTRIES - 1);
      ffpa_used_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk(clk), .load(reload), .shift(u_shift), .wr(wr_here),
        .sh_owner(u_owner[NX]), .sh_start(u_start[NX]), .sh_size(u_size[NX]),
        .wr_owner(uw_owner), .wr_start(uw_start), .wr_size(uw_size),
        .owner_r(u_owner[gi]), .start_r(u_start[gi]), .size_r(u_size[gi])
      );
    end
  endgenerate

  assign in_stall = (state_r != S_IDLE) || out_valid;

  // Sequencer. Alloc: U_FIND checks for an empty used slot over one turn, then
  // F_FIND finds the first fit (carving only if a slot exists), U_WRITE records it.
  // Reclaim: U_FIND finds owner and latches its area, then MERGE, SLOT (only if no merge), U_CLEAR.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid     <= 1'b0;
      pool_base_r   <= ffpa_pkg::POOL_BASE_RST;
      pool_length_r <= ffpa_pkg::POOL_LENGTH_RST;
      min_split_r   <= ffpa_pkg::MIN_SPLIT_RST;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          ffpa_pkg::REG_POOL_BASE:   pool_base_r   <= cfg_pwdata[23:0];
          ffpa_pkg::REG_POOL_LENGTH: pool_length_r <= cfg_pwdata[23:0];
          ffpa_pkg::REG_MIN_SPLIT:   min_split_r   <= cfg_pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (reload) begin
        state_r <= S_IDLE;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_valid && !in_stall) begin
              req_r   <= in_data;
              ucnt_r  <= '0;
              found_r <= 1'b0;
              a_r <= '0; l_r <= '0;
              if (in_data.job_id == 8'd0) begin
                st_r    <= in_data.req_type == ffpa_pkg::REQ_ALLOC ?
                           ffpa_pkg::ST_NO_USED_SLOT : ffpa_pkg::ST_JOB_UNKNOWN;
                state_r <= S_DONE;
              end else begin
                state_r <= S_U_FIND;
              end
            end
          end
          S_U_FIND: begin
            // alloc: look for empty slot; reclaim: look for owner
            ucnt_r <= ucnt_r + 1'b1;
            if (ucnt_r == USED_N - 1'b1) begin
              fcnt_r <= '0;
              if (req_r.req_type == ffpa_pkg::REQ_ALLOC) begin
                // fit is checked before the slot, so scan free areas either way
                slot_ok_r <= found_r || u_hit;
                found_r   <= 1'b0;
                state_r   <= S_F_FIND;
              end else if (!(found_r || u_hit)) begin
                st_r    <= ffpa_pkg::ST_JOB_UNKNOWN;
                state_r <= S_DONE;
              end else begin
                if (!found_r) begin
                  a_r <= u_start[0]; l_r <= u_size[0];
                end
                found_r <= 1'b0;
                state_r <= S_MERGE;
              end
            end else if (!found_r && u_hit) begin
              found_r <= 1'b1;
              a_r <= u_start[0]; l_r <= u_size[0];
            end
          end
          S_F_FIND: begin
            fcnt_r <= fcnt_r + 1'b1;
            if (fcnt_r == FREE_N - 1'b1) begin
              ucnt_r  <= '0;
              found_r <= 1'b0;
              if (!(found_r || f_fit)) begin
                st_r <= ffpa_pkg::ST_NO_FIT; a_r <= '0; l_r <= '0;
                state_r <= S_DONE;
              end else if (!slot_ok_r) begin
                st_r <= ffpa_pkg::ST_NO_USED_SLOT; a_r <= '0; l_r <= '0;
                state_r <= S_DONE;
              end else begin
                if (!found_r) begin
                  a_r <= carve_a; l_r <= carve_l;
                end
                state_r <= S_U_WRITE;
              end
            end else if (!found_r && f_fit) begin
              found_r <= 1'b1;
              a_r <= carve_a; l_r <= carve_l;
            end
          end
          S_U_WRITE: begin
            if (!found_r && u_owner[0] == 8'd0) found_r <= 1'b1;
            ucnt_r <= ucnt_r + 1'b1;
            if (ucnt_r == USED_N - 1'b1) begin
              st_r <= ffpa_pkg::ST_ALLOCATED;
              state_r <= S_DONE;
            end
          end
          S_MERGE: begin
            if (fcnt_r == FREE_N - 1'b1) begin
              fcnt_r <= '0;
              if (found_r || f_adj) begin
                ucnt_r <= '0; found_r <= 1'b0; state_r <= S_U_CLEAR;
              end else begin
                state_r <= S_SLOT;
              end
            end else begin
              fcnt_r <= fcnt_r + 1'b1;
              if (!found_r && f_adj) found_r <= 1'b1;
            end
          end
          S_SLOT: begin
            fcnt_r <= fcnt_r + 1'b1;
            if (fcnt_r == FREE_N - 1'b1) begin
              if (found_r || !f_valid[0]) begin
                ucnt_r <= '0; found_r <= 1'b0; state_r <= S_U_CLEAR;
              end else begin
                st_r <= ffpa_pkg::ST_NO_FREE_SLOT; a_r <= '0; l_r <= '0;
                state_r <= S_DONE;
              end
            end else if (!found_r && !f_valid[0]) begin
              found_r <= 1'b1;
            end
          end
          S_U_CLEAR: begin
            if (!found_r && u_owner[0] == req_r.job_id) found_r <= 1'b1;
            ucnt_r <= ucnt_r + 1'b1;
            if (ucnt_r == USED_N - 1'b1) begin
              st_r <= ffpa_pkg::ST_RECLAIMED;
              state_r <= S_DONE;
            end
          end
          S_DONE: begin
            out_valid <= 1'b1;
            out_data.status        <= st_r;
            out_data.block_address <= 24'(a_r);
            out_data.block_length  <= 24'(l_r);
            state_r <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE || $past(state_r) == S_DONE)
    else $error("result shown while busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("accept while busy");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid)
    else $error("result lost");
endmodule
`default_nettype wire

// ----- test/first_fit_partition_allocator_tb.sv -----
// Self-checking testbench for the first-fit partition allocator.
`default_nettype none
module first_fit_partition_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFREE = 16;
  localparam int NUSED = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 60;  // settling time after the last result; every request is already done here

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ffpa_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffpa_pkg::out_word_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  first_fit_partition_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator state.
  logic [23:0] pool_base_r, pool_length_r, min_split_r;
  logic        fr_valid [NFREE];
  logic [23:0] fr_start [NFREE];
  logic [23:0] fr_size  [NFREE];
  logic [7:0]  own_job  [NUSED];
  logic [23:0] own_start[NUSED];
  logic [23:0] own_size [NUSED];

  ffpa_pkg::out_word_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int status_seen[6];
  int words_sent = 0;

  // Idling knobs, in percent.
  int send_idle_pct = 0;
  int stall_pct = 0;
  // Long receiver hold-off, requested by bumping hold_req.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void reload_tables();
    for (int i = 0; i < NFREE; i++) begin
      fr_valid[i] = 1'b0;
      fr_start[i] = '0;
      fr_size[i] = '0;
    end
    for (int k = 0; k < NUSED; k++) begin
      own_job[k] = '0;
      own_start[k] = '0;
      own_size[k] = '0;
    end
    fr_valid[0] = 1'b1;
    fr_start[0] = pool_base_r;
    fr_size[0] = pool_length_r;
  endfunction

  function automatic ffpa_pkg::out_word_t predict_allocate(logic [7:0] job, logic [23:0] len);
    int fi;
    int uk;
    logic [23:0] rest;
    ffpa_pkg::out_word_t r;
    fi = -1;
    uk = -1;
    r = '0;
    if (job == 8'd0) begin
      r.status = ffpa_pkg::ST_NO_USED_SLOT;
      return r;
    end
    for (int i = 0; i < NFREE; i++)
      if (fi < 0 && fr_valid[i] && fr_size[i] >= len) fi = i;
    if (fi < 0) begin
      r.status = ffpa_pkg::ST_NO_FIT;
      return r;
    end
    for (int k = 0; k < NUSED; k++)
      if (uk < 0 && own_job[k] == 8'd0) uk = k;
    if (uk < 0) begin
      r.status = ffpa_pkg::ST_NO_USED_SLOT;
      return r;
    end
    rest = fr_size[fi] - len;
    if (rest < min_split_r) begin
      // leftover too small: the whole area goes
      r.block_address = fr_start[fi];
      r.block_length = fr_size[fi];
      fr_valid[fi] = 1'b0;
      fr_size[fi] = '0;
    end else begin
      r.block_address = fr_start[fi] + rest;
      r.block_length = len;
      fr_size[fi] = rest;
    end
    own_job[uk] = job;
    own_start[uk] = r.block_address;
    own_size[uk] = r.block_length;
    r.status = ffpa_pkg::ST_ALLOCATED;
    return r;
  endfunction

  function automatic ffpa_pkg::out_word_t predict_reclaim(logic [7:0] job);
    int uk;
    bit done;
    logic [23:0] a, l, area_end;
    ffpa_pkg::out_word_t r;
    uk = -1;
    done = 0;
    r = '0;
    if (job != 8'd0)
      for (int k = 0; k < NUSED; k++)
        if (uk < 0 && own_job[k] == job) uk = k;
    if (uk < 0) begin
      r.status = ffpa_pkg::ST_JOB_UNKNOWN;
      return r;
    end
    a = own_start[uk];
    l = own_size[uk];
    area_end = a + l;
    // one-sided merge into the first adjoining free area
    for (int i = 0; i < NFREE; i++) begin
      if (!done && fr_valid[i]) begin
        if (fr_start[i] + fr_size[i] == a) begin
          fr_size[i] = fr_size[i] + l;
          done = 1;
        end else if (fr_start[i] == area_end) begin
          fr_start[i] = a;
          fr_size[i] = fr_size[i] + l;
          done = 1;
        end
      end
    end
    for (int i = 0; i < NFREE; i++) begin
      if (!done && !fr_valid[i]) begin
        fr_valid[i] = 1'b1;
        fr_start[i] = a;
        fr_size[i] = l;
        done = 1;
      end
    end
    if (!done) begin
      r.status = ffpa_pkg::ST_NO_FREE_SLOT;
      return r;
    end
    own_job[uk] = '0;
    own_start[uk] = '0;
    own_size[uk] = '0;
    r.status = ffpa_pkg::ST_RECLAIMED;
    r.block_address = a;
    r.block_length = l;
    return r;
  endfunction

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_partition_allocator verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: sampled values at the edge are the pre-edge values.
  always @(posedge clk) begin
    ffpa_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d", out_data.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.block_address != want.block_address) begin
          $error("block_address: expected %h, got %h", want.block_address,
                 out_data.block_address);
          errors++;
        end
        if (out_data.block_length != want.block_length) begin
          $error("block_length: expected %h, got %h", want.block_length,
                 out_data.block_length);
          errors++;
        end
        if (out_data.status < 6) status_seen[out_data.status]++;
      end
    end
  end

  // Offer one word, hold it until taken, then predict its result.
  task automatic send_word(ffpa_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.req_type == ffpa_pkg::REQ_ALLOC)
      pending_results.push_back(predict_allocate(w.job_id, w.request_length));
    else
      pending_results.push_back(predict_reclaim(w.job_id));
    words_sent++;
  endtask

  task automatic send_req(logic kind, logic [7:0] job, logic [23:0] len);
    ffpa_pkg::in_word_t w;
    w.req_type = kind;
    w.job_id = job;
    w.request_length = len;
    send_word(w);
  endtask

  // Lower valid and wait for every outstanding result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {8'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      ffpa_pkg::REG_POOL_BASE: begin
        pool_base_r = val;
        reload_tables();
      end
      ffpa_pkg::REG_POOL_LENGTH: begin
        pool_length_r = val;
        reload_tables();
      end
      default: min_split_r = val;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 24'($urandom_range(0, 4000));
    if (r < 80) return 24'($urandom_range(0, 20000));
    if (r < 90) return 24'($urandom);
    if (r < 95) return 24'd0;
    return pool_length_r;
  endfunction

  // Mostly well-formed traffic: allocations and reclaims of live jobs,
  // with a little noise (unknown jobs, job zero).
  task automatic random_word();
    int r;
    int live[$];
    ffpa_pkg::in_word_t w;
    r = $urandom_range(99);
    w.request_length = 24'($urandom);
    if (r < 50) begin
      w.req_type = ffpa_pkg::REQ_ALLOC;
      w.job_id = 8'($urandom_range(1, 255));
      w.request_length = pick_length();
    end else if (r < 92) begin
      w.req_type = ffpa_pkg::REQ_RECLAIM;
      for (int k = 0; k < NUSED; k++)
        if (own_job[k] != 8'd0) live.push_back(own_job[k]);
      if (live.size() != 0) w.job_id = 8'(live[$urandom_range(0, live.size() - 1)]);
      else w.job_id = 8'($urandom_range(1, 255));
    end else begin
      w.req_type = 1'($urandom);
      w.job_id = ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom);
    end
    send_word(w);
  endtask

  task automatic test_directed();
    send_req(ffpa_pkg::REQ_ALLOC, 8'd1, 24'd1000);         // split: top end carved off
    send_req(ffpa_pkg::REQ_ALLOC, 8'd255, 24'd0);          // zero-length split
    send_req(ffpa_pkg::REQ_ALLOC, 8'd0, 24'd10);           // job zero refused on allocate
    send_req(ffpa_pkg::REQ_RECLAIM, 8'd0, 24'hFFFFFF);     // job zero on reclaim
    send_req(ffpa_pkg::REQ_RECLAIM, 8'd77, 24'd0);         // unknown job
    send_req(ffpa_pkg::REQ_ALLOC, 8'd2, 24'hFFFFFF);       // nothing fits
    send_req(ffpa_pkg::REQ_ALLOC, 8'd5, 24'd300);          // duplicate ids
    send_req(ffpa_pkg::REQ_ALLOC, 8'd5, 24'd400);
    send_req(ffpa_pkg::REQ_RECLAIM, 8'd5, 24'd0);          // lowest slot with the id goes
    send_req(ffpa_pkg::REQ_RECLAIM, 8'd1, 24'd0);          // merge
    send_req(ffpa_pkg::REQ_ALLOC, 8'd3, 24'd100000);       // leftover above the minimum: split
    send_req(ffpa_pkg::REQ_RECLAIM, 8'd3, 24'd0);
    // fill the allocation table, then overflow it
    for (int j = 0; j < 14; j++) send_req(ffpa_pkg::REQ_ALLOC, 8'(10 + j), 24'd500);
    send_req(ffpa_pkg::REQ_ALLOC, 8'd99, 24'd10);
    send_req(ffpa_pkg::REQ_ALLOC, 8'd98, 24'hFFFFFF);      // table full and nothing fits
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int j = 0; j < n; j++) random_word();
    drain();
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    for (int j = 0; j < 40; j++) random_word();
    drain();   // sender pauses until every result is back
  endtask

  // Sweep register settings, extremes included, with traffic at each.
  task automatic test_config_sweep();
    logic [23:0] bases[5];
    logic [23:0] lens[5];
    logic [23:0] splits[4];
    bases = '{24'd0, 24'hFFFFFF, 24'hFFFF00, 24'd4096, 24'd10240};
    lens = '{24'd0, 24'hFFFFFF, 24'h000200, 24'd8000, 24'd102400};
    splits = '{24'd0, 24'hFFFFFF, 24'd1, 24'd100};
    send_idle_pct = 22;
    stall_pct = 22;
    for (int b = 0; b < 5; b++) begin
      write_reg(ffpa_pkg::REG_POOL_BASE, bases[b]);
      write_reg(ffpa_pkg::REG_POOL_LENGTH, lens[b]);
      write_reg(ffpa_pkg::REG_MIN_SPLIT, splits[b % 4]);
      send_req(ffpa_pkg::REQ_ALLOC, 8'd7, 24'h80);  // near top of address space this wraps
      for (int j = 0; j < 25; j++) random_word();
    end
    write_reg(ffpa_pkg::REG_POOL_BASE, ffpa_pkg::POOL_BASE_RST);
    write_reg(ffpa_pkg::REG_POOL_LENGTH, 24'd3000);
    write_reg(ffpa_pkg::REG_MIN_SPLIT, 24'd0);
    // many tiny areas to exhaust the free table on reclaim
    for (int j = 0; j < 60; j++) random_word();
    drain();
  endtask

  initial begin
    pool_base_r = ffpa_pkg::POOL_BASE_RST;
    pool_length_r = ffpa_pkg::POOL_LENGTH_RST;
    min_split_r = ffpa_pkg::MIN_SPLIT_RST;
    reload_tables();
    for (int s = 0; s < 6; s++) status_seen[s] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(300, 0, 0);
    test_random_phase(250, 79, 0);
    test_random_phase(300, 0, 79);
    test_random_phase(250, 22, 22);
    test_backpressure();
    test_config_sweep();

    $display("Sent %0d request words over idle, stall and register-sweep phases.",
             words_sent);
    $display("Status mix: alloc %0d nofit %0d noslot %0d reclaim %0d unknown %0d nofree %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("first_fit_partition_allocator verification clean");
    end else begin
      $display("first_fit_partition_allocator verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
